@@ sv/cie_pkg.sv @@
package cie_pkg;

  // Flag positions inside the six-bit flag register.
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 4;
  localparam int unsigned FL_N = 5;

  localparam logic [5:0] FLAGS_RESET = 6'b000100;
  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] SIGN_MASK   = 8'h80;
  localparam logic [7:0] BIT6_MASK   = 8'h40;

  // Group field (opcode bits 7:5) of the accumulator ALU column.
  localparam logic [2:0] GRP_ORA = 3'd0;
  localparam logic [2:0] GRP_AND = 3'd1;
  localparam logic [2:0] GRP_EOR = 3'd2;
  localparam logic [2:0] GRP_ADC = 3'd3;
  localparam logic [2:0] GRP_STA = 3'd4;
  localparam logic [2:0] GRP_LDA = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd6;
  localparam logic [2:0] GRP_SBC = 3'd7;
  localparam logic [1:0] ALU_COLUMN = 2'b01;

  // Shift kinds (opcode bits 6:5) and shift addressing forms (opcode bits 4:0).
  localparam logic [1:0] SH_ASL = 2'd0;
  localparam logic [1:0] SH_ROL = 2'd1;
  localparam logic [1:0] SH_LSR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;
  localparam logic [4:0] SHM_ZP   = 5'h06;
  localparam logic [4:0] SHM_ACC  = 5'h0A;
  localparam logic [4:0] SHM_ZPX  = 5'h16;
  localparam logic [4:0] SHM_ABS  = 5'h0E;
  localparam logic [4:0] SHM_ABSX = 5'h1E;

  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_STA_IMM = 8'h89;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS = 8'hAE;
  localparam logic [7:0] OP_LDX_ABY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS = 8'hAC;
  localparam logic [7:0] OP_LDY_ABX = 8'hBC;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STX_ZPY = 8'h96;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STY_ZPX = 8'h94;
  localparam logic [7:0] OP_STY_ABS = 8'h8C;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_TAY     = 8'hA8;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_TYA     = 8'h98;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_INC_ZPX = 8'hF6;
  localparam logic [7:0] OP_INC_ABS = 8'hEE;
  localparam logic [7:0] OP_INC_ABX = 8'hFE;
  localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
  localparam logic [7:0] OP_DEC_ZPX = 8'hD6;
  localparam logic [7:0] OP_DEC_ABS = 8'hCE;
  localparam logic [7:0] OP_DEC_ABX = 8'hDE;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_DEY     = 8'h88;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_SED     = 8'hF8;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_CLI     = 8'h58;
  localparam logic [7:0] OP_CLV     = 8'hB8;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_JMP_IND = 8'h6C;
  localparam logic [7:0] OP_BCC     = 8'h90;
  localparam logic [7:0] OP_BCS     = 8'hB0;
  localparam logic [7:0] OP_BEQ     = 8'hF0;
  localparam logic [7:0] OP_BMI     = 8'h30;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_BPL     = 8'h10;
  localparam logic [7:0] OP_BVS     = 8'h70;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_BIT_ABS = 8'h2C;

  typedef struct packed {
    logic [7:0]  func;
    logic [7:0]  operand_byte;
    logic [15:0] effective_address;
    logic [15:0] fallthrough_pc;
  } req_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [5:0] flags;
  } arch_t;

  typedef struct packed {
    logic        write_enable;
    logic [7:0]  write_value;
    logic [15:0] next_pc;
    logic        halted;
    logic [7:0]  status_flags;
    logic [7:0]  accumulator;
  } rsp_t;

endpackage

@@ sv/cie_if.sv @@
// Request channel: one instruction with its fetched operand and addresses.
interface cie_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  func;
  logic [7:0]  operand_byte;
  logic [15:0] effective_address;
  logic [15:0] fallthrough_pc;

  modport source (output valid, func, operand_byte, effective_address, fallthrough_pc,
                  input ready);
  modport sink (input valid, func, operand_byte, effective_address, fallthrough_pc,
                output ready);
endinterface

// Result channel: write-back, next PC, halt and visible processor state.
interface cie_rsp_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [7:0]  write_value;
  logic [15:0] next_pc;
  logic        halted;
  logic [7:0]  status_flags;
  logic [7:0]  accumulator;

  modport source (output valid, write_enable, write_value, next_pc, halted, status_flags,
                  accumulator, input ready);
  modport sink (input valid, write_enable, write_value, next_pc, halted, status_flags,
                accumulator, output ready);
endinterface

@@ sv/cie_exec.sv @@
// Combinational execute: decodes one opcode and produces the next
// architectural state and the result item.
module cie_exec (
  input  cie_pkg::req_t  req,
  input  cie_pkg::arch_t cur,
  output cie_pkg::arch_t nxt,
  output cie_pkg::rsp_t  res
);

  logic [7:0] op;
  logic [7:0] m;
  logic [7:0] alu_b;
  logic [8:0] sum;
  logic [7:0] add_r;
  logic [7:0] diff;
  logic [7:0] sh_in;
  logic [7:0] sh_r;
  logic       sh_c;
  logic       take;
  logic       we;
  logic [7:0] wv;
  logic [15:0] npc;
  logic       halt;
  logic [7:0] nz_val;
  logic       nz_upd;

  assign op = req.func;
  assign m  = req.operand_byte;

  // Shared binary adder for ADC and SBC (SBC adds the inverted operand).
  assign alu_b = (op[7:5] == cie_pkg::GRP_SBC) ? ~m : m;
  assign sum   = {1'b0, cur.a} + {1'b0, alu_b} + {8'd0, cur.flags[cie_pkg::FL_C]};
  assign add_r = sum[7:0];
  assign diff  = cur.a - m;

  // Shift unit; the source is A for the accumulator form and memory otherwise.
  assign sh_in = (op[4:0] == cie_pkg::SHM_ACC) ? cur.a : m;
  always_comb begin
    sh_r = 8'd0;
    sh_c = 1'b0;
    case (op[6:5])
      cie_pkg::SH_ASL: begin
        sh_r = {sh_in[6:0], 1'b0};
        sh_c = sh_in[7];
      end
      cie_pkg::SH_ROL: begin
        sh_r = {sh_in[6:0], cur.flags[cie_pkg::FL_C]};
        sh_c = sh_in[7];
      end
      cie_pkg::SH_LSR: begin
        sh_r = {1'b0, sh_in[7:1]};
        sh_c = sh_in[0];
      end
      default: begin
        sh_r = {cur.flags[cie_pkg::FL_C], sh_in[7:1]};
        sh_c = sh_in[0];
      end
    endcase
  end

  always_comb begin
    nxt    = cur;
    we     = 1'b0;
    wv     = 8'd0;
    halt   = 1'b0;
    take   = 1'b0;
    nz_val = 8'd0;
    nz_upd = 1'b0;
    npc    = req.fallthrough_pc;

    if (op[1:0] == cie_pkg::ALU_COLUMN) begin
      case (op[7:5])
        cie_pkg::GRP_ORA: begin nxt.a = cur.a | m; nz_val = cur.a | m; nz_upd = 1'b1; end
        cie_pkg::GRP_AND: begin nxt.a = cur.a & m; nz_val = cur.a & m; nz_upd = 1'b1; end
        cie_pkg::GRP_EOR: begin nxt.a = cur.a ^ m; nz_val = cur.a ^ m; nz_upd = 1'b1; end
        cie_pkg::GRP_STA: begin
          if (op != cie_pkg::OP_STA_IMM) begin
            we = 1'b1;
            wv = cur.a;
          end
        end
        cie_pkg::GRP_LDA: begin nxt.a = m; nz_val = m; nz_upd = 1'b1; end
        cie_pkg::GRP_CMP: begin
          nxt.flags[cie_pkg::FL_C] = (cur.a >= m);
          nz_val = diff;
          nz_upd = 1'b1;
        end
        default: begin
          // ADC and SBC
          nxt.a = add_r;
          nxt.flags[cie_pkg::FL_C] = sum[8];
          nxt.flags[cie_pkg::FL_V] = ~(cur.a[7] ^ alu_b[7]) & (cur.a[7] ^ add_r[7]);
          nz_val = add_r;
          nz_upd = 1'b1;
        end
      endcase
    end else if (!op[7] && (op[4:0] inside {cie_pkg::SHM_ZP, cie_pkg::SHM_ACC,
                 cie_pkg::SHM_ZPX, cie_pkg::SHM_ABS, cie_pkg::SHM_ABSX})) begin
      nxt.flags[cie_pkg::FL_C] = sh_c;
      nz_val = sh_r;
      nz_upd = 1'b1;
      if (op[4:0] == cie_pkg::SHM_ACC) begin
        nxt.a = sh_r;
      end else begin
        we = 1'b1;
        wv = sh_r;
      end
    end else begin
      case (op) inside
        cie_pkg::OP_LDX_IMM, cie_pkg::OP_LDX_ZP, cie_pkg::OP_LDX_ZPY, cie_pkg::OP_LDX_ABS,
        cie_pkg::OP_LDX_ABY: begin
          nxt.x = m; nz_val = m; nz_upd = 1'b1;
        end
        cie_pkg::OP_LDY_IMM, cie_pkg::OP_LDY_ZP, cie_pkg::OP_LDY_ZPX, cie_pkg::OP_LDY_ABS,
        cie_pkg::OP_LDY_ABX: begin
          nxt.y = m; nz_val = m; nz_upd = 1'b1;
        end
        cie_pkg::OP_STX_ZP, cie_pkg::OP_STX_ZPY, cie_pkg::OP_STX_ABS: begin
          we = 1'b1; wv = cur.x;
        end
        cie_pkg::OP_STY_ZP, cie_pkg::OP_STY_ZPX, cie_pkg::OP_STY_ABS: begin
          we = 1'b1; wv = cur.y;
        end
        cie_pkg::OP_TAX: begin nxt.x = cur.a; nz_val = cur.a; nz_upd = 1'b1; end
        cie_pkg::OP_TAY: begin nxt.y = cur.a; nz_val = cur.a; nz_upd = 1'b1; end
        cie_pkg::OP_TSX: begin nxt.x = cur.s; nz_val = cur.s; nz_upd = 1'b1; end
        cie_pkg::OP_TXA: begin nxt.a = cur.x; nz_val = cur.x; nz_upd = 1'b1; end
        cie_pkg::OP_TXS: nxt.s = cur.x;
        cie_pkg::OP_TYA: begin nxt.a = cur.y; nz_val = cur.y; nz_upd = 1'b1; end
        cie_pkg::OP_INC_ZP, cie_pkg::OP_INC_ZPX, cie_pkg::OP_INC_ABS,
        cie_pkg::OP_INC_ABX: begin
          we = 1'b1; wv = m + 8'd1; nz_val = m + 8'd1; nz_upd = 1'b1;
        end
        cie_pkg::OP_DEC_ZP, cie_pkg::OP_DEC_ZPX, cie_pkg::OP_DEC_ABS,
        cie_pkg::OP_DEC_ABX: begin
          we = 1'b1; wv = m - 8'd1; nz_val = m - 8'd1; nz_upd = 1'b1;
        end
        cie_pkg::OP_INX: begin nxt.x = cur.x + 8'd1; nz_val = cur.x + 8'd1; nz_upd = 1'b1; end
        cie_pkg::OP_INY: begin nxt.y = cur.y + 8'd1; nz_val = cur.y + 8'd1; nz_upd = 1'b1; end
        cie_pkg::OP_DEX: begin nxt.x = cur.x - 8'd1; nz_val = cur.x - 8'd1; nz_upd = 1'b1; end
        cie_pkg::OP_DEY: begin nxt.y = cur.y - 8'd1; nz_val = cur.y - 8'd1; nz_upd = 1'b1; end
        cie_pkg::OP_SEC: nxt.flags[cie_pkg::FL_C] = 1'b1;
        cie_pkg::OP_SED: nxt.flags[cie_pkg::FL_D] = 1'b1;
        cie_pkg::OP_SEI: nxt.flags[cie_pkg::FL_I] = 1'b1;
        cie_pkg::OP_CLC: nxt.flags[cie_pkg::FL_C] = 1'b0;
        cie_pkg::OP_CLD: nxt.flags[cie_pkg::FL_D] = 1'b0;
        cie_pkg::OP_CLI: nxt.flags[cie_pkg::FL_I] = 1'b0;
        cie_pkg::OP_CLV: nxt.flags[cie_pkg::FL_V] = 1'b0;
        cie_pkg::OP_JMP_ABS, cie_pkg::OP_JMP_IND: npc = req.effective_address;
        cie_pkg::OP_BCC: take = ~cur.flags[cie_pkg::FL_C];
        cie_pkg::OP_BCS: take = cur.flags[cie_pkg::FL_C];
        cie_pkg::OP_BEQ: take = cur.flags[cie_pkg::FL_Z];
        cie_pkg::OP_BMI: take = cur.flags[cie_pkg::FL_N];
        cie_pkg::OP_BNE: take = ~cur.flags[cie_pkg::FL_Z];
        cie_pkg::OP_BPL: take = ~cur.flags[cie_pkg::FL_N];
        cie_pkg::OP_BVS: take = cur.flags[cie_pkg::FL_V];
        cie_pkg::OP_BIT_ZP, cie_pkg::OP_BIT_ABS: begin
          nxt.flags[cie_pkg::FL_Z] = ((m & cur.a) == 8'd0);
          nxt.flags[cie_pkg::FL_V] = ((m & cie_pkg::BIT6_MASK) != 8'd0);
          nxt.flags[cie_pkg::FL_N] = ((m & cie_pkg::SIGN_MASK) != 8'd0);
        end
        cie_pkg::OP_BRK: halt = 1'b1;
        default: ;
      endcase
    end

    if (nz_upd) begin
      nxt.flags[cie_pkg::FL_Z] = (nz_val == 8'd0);
      nxt.flags[cie_pkg::FL_N] = nz_val[7];
    end

    // Relative branch: sign-extended offset added to the fall-through address.
    if (take) begin
      npc = req.fallthrough_pc + {{8{m[7]}}, m};
    end
  end

  always_comb begin
    res.write_enable = we;
    res.write_value  = wv;
    res.next_pc      = npc;
    res.halted       = halt;
    res.status_flags = {nxt.flags[cie_pkg::FL_N], nxt.flags[cie_pkg::FL_V], 1'b1, 1'b0,
                        nxt.flags[cie_pkg::FL_D], nxt.flags[cie_pkg::FL_I],
                        nxt.flags[cie_pkg::FL_Z], nxt.flags[cie_pkg::FL_C]};
    res.accumulator  = nxt.a;
  end

endmodule

@@ sv/cpu_8bit_instruction_execute_core.sv @@
// Execute core for a 6502-style 8-bit processor. Each request carries one
// opcode with its already fetched operand byte, effective address and
// fall-through PC; the core updates A, X, Y, S and the C Z I D V N flags
// and returns one result per request: an optional byte write-back, the next
// PC (fall-through, branch or jump target), a halt mark for BRK, the packed
// status byte and the accumulator. A request is taken into an input register
// and executed from there by single-pass decode and ALU logic into the
// result register, which presents it on the result channel. The core
// sustains one request per cycle; only a stalled result register slows
// it down. Arithmetic is always binary, and opcodes outside the decoded set
// pass through as no-ops.
module cpu_8bit_instruction_execute_core (
  input  logic          clk,
  input  logic          rst,
  cie_req_if.sink       req,
  cie_rsp_if.source     rsp
);

  cie_pkg::req_t  s1_q;
  logic           s1_valid;
  cie_pkg::rsp_t  out_q;
  logic           out_valid;
  cie_pkg::arch_t arch;
  cie_pkg::arch_t arch_next;
  cie_pkg::rsp_t  res_next;
  logic           out_free;
  logic           advance;

  // The result register can load when it is empty or is being drained this
  // cycle. The input register advances into it whenever that is true, so a
  // new request is taken back to back as long as the output keeps moving.
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  // Architectural state is committed in the same cycle as the result is
  // registered, so the next instruction always sees the updated registers.
  cie_exec u_exec (
    .req (s1_q),
    .cur (arch),
    .nxt (arch_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      arch.a      <= 8'd0;
      arch.x      <= 8'd0;
      arch.y      <= 8'd0;
      arch.s      <= cie_pkg::SP_RESET;
      arch.flags  <= cie_pkg::FLAGS_RESET;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        arch <= arch_next;
      end
    end
  end

  // Payload registers carry no reset; they are qualified by the valid bits.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_q.func              <= req.func;
      s1_q.operand_byte      <= req.operand_byte;
      s1_q.effective_address <= req.effective_address;
      s1_q.fallthrough_pc    <= req.fallthrough_pc;
    end
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.write_enable = out_q.write_enable;
  assign rsp.write_value  = out_q.write_value;
  assign rsp.next_pc      = out_q.next_pc;
  assign rsp.halted       = out_q.halted;
  assign rsp.status_flags = out_q.status_flags;
  assign rsp.accumulator  = out_q.accumulator;

endmodule

@@ sv/cie_checker.sv @@
// Port-level checks on the execute core.
module cie_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        write_enable,
  input logic [7:0]  write_value,
  input logic [15:0] next_pc,
  input logic        halted,
  input logic [7:0]  status_flags
);

  // Reset empties the pipeline, so no result is shown right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_pc) && $stable(write_value)
      && $stable(status_flags))
    else $error("stalled result changed");

  // The write data is cleared when there is no write-back.
  a_wv_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !write_enable |-> write_value == 8'd0)
    else $error("write data without write enable");

  // The fixed bit reads one and the break position reads zero.
  a_status_fixed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status_flags[5] && !status_flags[4])
    else $error("fixed status bits wrong");

  // A halting instruction never stores.
  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && halted |-> !write_enable)
    else $error("write on halt");

endmodule

bind cpu_8bit_instruction_execute_core cie_checker u_cie_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .write_enable (rsp.write_enable),
  .write_value  (rsp.write_value),
  .next_pc      (rsp.next_pc),
  .halted       (rsp.halted),
  .status_flags (rsp.status_flags)
);

@@ tb/sv/cie_retire_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the execute core. It keeps its own copy of the
// processor state, predicts the result of every accepted request and compares
// each accepted result with the oldest prediction still waiting.
module cie_retire_checker (
  input  logic clk,
  input  logic rst,
  cie_req_if   req_mon,
  cie_rsp_if   rsp_mon,
  output int   errors,
  output int   pending
);
  import cie_pkg::*;

  typedef struct {
    req_t cause;
    rsp_t want;
  } retire_t;

  arch_t   cpu;
  retire_t retire_q[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic logic [5:0] nz_of(input logic [5:0] f, input logic [7:0] v);
    logic [5:0] g;
    g = f;
    g[FL_Z] = (v == 8'h00);
    g[FL_N] = v[7];
    return g;
  endfunction

  // Executes one instruction on the local state and builds its result.
  task automatic execute_instr(input req_t r, output rsp_t o);
    logic [7:0] m;
    logic [7:0] res;
    logic [7:0] addend;
    logic [7:0] sh_in;
    logic [8:0] sum;
    logic [4:0] form;
    logic [5:0] f;
    logic       take;
    m = r.operand_byte;
    f = cpu.flags;
    take = 1'b0;
    form = r.func[4:0];
    o = '0;
    o.next_pc = r.fallthrough_pc;
    if (r.func[1:0] == ALU_COLUMN) begin
      case (r.func[7:5])
        GRP_ORA: begin
          cpu.a = cpu.a | m;
          f = nz_of(f, cpu.a);
        end
        GRP_AND: begin
          cpu.a = cpu.a & m;
          f = nz_of(f, cpu.a);
        end
        GRP_EOR: begin
          cpu.a = cpu.a ^ m;
          f = nz_of(f, cpu.a);
        end
        GRP_ADC, GRP_SBC: begin
          // Subtraction is addition of the inverted operand with carry as not-borrow.
          addend = (r.func[7:5] == GRP_SBC) ? ~m : m;
          sum = {1'b0, cpu.a} + {1'b0, addend} + {8'h00, f[FL_C]};
          res = sum[7:0];
          f[FL_C] = sum[8];
          f[FL_V] = ~(cpu.a[7] ^ addend[7]) & (cpu.a[7] ^ res[7]);
          cpu.a = res;
          f = nz_of(f, res);
        end
        GRP_STA: begin
          if (r.func != OP_STA_IMM) begin
            o.write_enable = 1'b1;
            o.write_value = cpu.a;
          end
        end
        GRP_LDA: begin
          cpu.a = m;
          f = nz_of(f, cpu.a);
        end
        GRP_CMP: begin
          res = cpu.a - m;
          f[FL_C] = (cpu.a >= m);
          f = nz_of(f, res);
        end
        default: ;
      endcase
    end else if (!r.func[7] && (form == SHM_ZP || form == SHM_ACC || form == SHM_ZPX ||
                                form == SHM_ABS || form == SHM_ABSX)) begin
      sh_in = (form == SHM_ACC) ? cpu.a : m;
      case (r.func[6:5])
        SH_ASL: res = {sh_in[6:0], 1'b0};
        SH_ROL: res = {sh_in[6:0], f[FL_C]};
        SH_LSR: res = {1'b0, sh_in[7:1]};
        default: res = {f[FL_C], sh_in[7:1]};
      endcase
      f[FL_C] = r.func[6] ? sh_in[0] : sh_in[7];
      f = nz_of(f, res);
      if (form == SHM_ACC) begin
        cpu.a = res;
      end else begin
        o.write_enable = 1'b1;
        o.write_value = res;
      end
    end else begin
      case (r.func)
        OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY: begin
          cpu.x = m;
          f = nz_of(f, cpu.x);
        end
        OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX: begin
          cpu.y = m;
          f = nz_of(f, cpu.y);
        end
        OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS: begin
          o.write_enable = 1'b1;
          o.write_value = cpu.x;
        end
        OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS: begin
          o.write_enable = 1'b1;
          o.write_value = cpu.y;
        end
        OP_TAX: begin
          cpu.x = cpu.a;
          f = nz_of(f, cpu.x);
        end
        OP_TAY: begin
          cpu.y = cpu.a;
          f = nz_of(f, cpu.y);
        end
        OP_TSX: begin
          cpu.x = cpu.s;
          f = nz_of(f, cpu.x);
        end
        OP_TXA: begin
          cpu.a = cpu.x;
          f = nz_of(f, cpu.a);
        end
        OP_TXS: cpu.s = cpu.x;
        OP_TYA: begin
          cpu.a = cpu.y;
          f = nz_of(f, cpu.a);
        end
        OP_INC_ZP, OP_INC_ZPX, OP_INC_ABS, OP_INC_ABX: begin
          o.write_enable = 1'b1;
          o.write_value = m + 8'd1;
          f = nz_of(f, o.write_value);
        end
        OP_DEC_ZP, OP_DEC_ZPX, OP_DEC_ABS, OP_DEC_ABX: begin
          o.write_enable = 1'b1;
          o.write_value = m - 8'd1;
          f = nz_of(f, o.write_value);
        end
        OP_INX: begin
          cpu.x = cpu.x + 8'd1;
          f = nz_of(f, cpu.x);
        end
        OP_INY: begin
          cpu.y = cpu.y + 8'd1;
          f = nz_of(f, cpu.y);
        end
        OP_DEX: begin
          cpu.x = cpu.x - 8'd1;
          f = nz_of(f, cpu.x);
        end
        OP_DEY: begin
          cpu.y = cpu.y - 8'd1;
          f = nz_of(f, cpu.y);
        end
        OP_SEC: f[FL_C] = 1'b1;
        OP_SED: f[FL_D] = 1'b1;
        OP_SEI: f[FL_I] = 1'b1;
        OP_CLC: f[FL_C] = 1'b0;
        OP_CLD: f[FL_D] = 1'b0;
        OP_CLI: f[FL_I] = 1'b0;
        OP_CLV: f[FL_V] = 1'b0;
        OP_JMP_ABS, OP_JMP_IND: o.next_pc = r.effective_address;
        OP_BCC: take = !f[FL_C];
        OP_BCS: take = f[FL_C];
        OP_BEQ: take = f[FL_Z];
        OP_BMI: take = f[FL_N];
        OP_BNE: take = !f[FL_Z];
        OP_BPL: take = !f[FL_N];
        OP_BVS: take = f[FL_V];
        OP_BIT_ZP, OP_BIT_ABS: begin
          f[FL_Z] = ((m & cpu.a) == 8'h00);
          f[FL_V] = m[6];
          f[FL_N] = m[7];
        end
        OP_BRK: o.halted = 1'b1;
        default: ;
      endcase
    end
    if (take) begin
      o.next_pc = r.fallthrough_pc + {{8{m[7]}}, m};
    end
    cpu.flags = f;
    o.status_flags = {f[FL_N], f[FL_V], 1'b1, 1'b0, f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
    o.accumulator = cpu.a;
  endtask

  task automatic flag_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got, input req_t cause);
    errors++;
    if (errors <= 10) begin
      $display("mismatch in %s: op %02h operand %02h, expected %h, got %h",
               field, cause.func, cause.operand_byte, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    retire_t entry;
    rsp_t    got;
    rsp_t    want;
    req_t    taken;
    if (rst) begin
      cpu.a = 8'h00;
      cpu.x = 8'h00;
      cpu.y = 8'h00;
      cpu.s = SP_RESET;
      cpu.flags = FLAGS_RESET;
      retire_q.delete();
      pending <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.write_enable = rsp_mon.write_enable;
        got.write_value = rsp_mon.write_value;
        got.next_pc = rsp_mon.next_pc;
        got.halted = rsp_mon.halted;
        got.status_flags = rsp_mon.status_flags;
        got.accumulator = rsp_mon.accumulator;
        if (retire_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("result with nothing outstanding: next_pc %h", got.next_pc);
          end
        end else begin
          entry = retire_q.pop_front();
          if (got.write_enable !== entry.want.write_enable)
            flag_mismatch("write_enable", entry.want.write_enable, got.write_enable,
                          entry.cause);
          if (got.write_value !== entry.want.write_value)
            flag_mismatch("write_value", entry.want.write_value, got.write_value,
                          entry.cause);
          if (got.next_pc !== entry.want.next_pc)
            flag_mismatch("next_pc", entry.want.next_pc, got.next_pc, entry.cause);
          if (got.halted !== entry.want.halted)
            flag_mismatch("halted", entry.want.halted, got.halted, entry.cause);
          if (got.status_flags !== entry.want.status_flags)
            flag_mismatch("status_flags", entry.want.status_flags, got.status_flags,
                          entry.cause);
          if (got.accumulator !== entry.want.accumulator)
            flag_mismatch("accumulator", entry.want.accumulator, got.accumulator,
                          entry.cause);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        taken.func = req_mon.func;
        taken.operand_byte = req_mon.operand_byte;
        taken.effective_address = req_mon.effective_address;
        taken.fallthrough_pc = req_mon.fallthrough_pc;
        execute_instr(taken, want);
        entry.cause = taken;
        entry.want = want;
        retire_q.push_back(entry);
      end
      pending <= retire_q.size();
    end
  end

endmodule

@@ tb/sv/tb_cpu_8bit_instruction_execute_core.sv @@
`timescale 1ns / 100ps

// Top of the execute core testbench. It builds the clock and reset, drives
// instruction requests into the core, paces the result side, and turns the
// checker's count of failures into the final verdict. All prediction and
// comparison lives in the checker that sits beside the core.
module tb_cpu_8bit_instruction_execute_core;
  import cie_pkg::*;

  // No accepted request or result for this many cycles means the core hung.
  // A correct run never waits more than a sender gap, a receiver stall and a pass
  // through the input and result registers, so this is far beyond any honest pause.
  localparam int WATCHDOG_LIMIT  = 500;
  localparam int RANDOM_REQUESTS = 1400;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;

  // Opcodes outside the ALU column and the shift group, drawn from at random.
  logic [7:0] misc_ops[$];

  cie_req_if req_bus();
  cie_rsp_if rsp_bus();

  cpu_8bit_instruction_execute_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  cie_retire_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req_mon (req_bus),
    .rsp_mon (rsp_bus),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t instr(input logic [7:0] op, input logic [7:0] m,
                                 input logic [15:0] ea, input logic [15:0] pc);
    req_t r;
    r.func = op;
    r.operand_byte = m;
    r.effective_address = ea;
    r.fallthrough_pc = pc;
    return r;
  endfunction

  // Random request. Most opcodes come from the decoded set so that the
  // register state keeps moving; the rest are any byte at all, which also
  // exercises the opcodes that the core must pass through untouched.
  function automatic req_t draw_instr();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 19);
    r.func = 8'($urandom);
    if (pick < 8) begin
      r.func[1:0] = ALU_COLUMN;
    end else if (pick < 11) begin
      r.func[7] = 1'b0;
      case ($urandom_range(0, 4))
        0: r.func[4:0] = SHM_ZP;
        1: r.func[4:0] = SHM_ACC;
        2: r.func[4:0] = SHM_ZPX;
        3: r.func[4:0] = SHM_ABS;
        default: r.func[4:0] = SHM_ABSX;
      endcase
    end else if (pick < 17) begin
      r.func = misc_ops[$urandom_range(0, misc_ops.size() - 1)];
    end
    // Operands favor the values where carry, overflow and sign flip.
    case ($urandom_range(0, 7))
      0: r.operand_byte = 8'h00;
      1: r.operand_byte = 8'hFF;
      2: r.operand_byte = 8'h80;
      3: r.operand_byte = 8'h7F;
      default: r.operand_byte = 8'($urandom);
    endcase
    r.effective_address = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    r.fallthrough_pc = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    return r;
  endfunction

  // Presents one request after a random gap and holds it until accepted.
  // Valid is only lowered when a gap follows, so a back-to-back request
  // never sees valid dropped and raised within the same step.
  task automatic send_instr(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= r.func;
    req_bus.operand_byte <= r.operand_byte;
    req_bus.effective_address <= r.effective_address;
    req_bus.fallthrough_pc <= r.fallthrough_pc;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Stops sending and waits until every outstanding request has retired.
  // The first edge is always taken so the checker's count is current.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: before each result it stalls for a random number of cycles,
  // then holds ready high until a result is taken.
  initial begin
    int stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // A hang shows as a long stretch with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cpu_8bit_instruction_execute_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.func <= '0;
    req_bus.operand_byte <= '0;
    req_bus.effective_address <= '0;
    req_bus.fallthrough_pc <= '0;
    misc_ops = '{OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY,
                 OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX,
                 OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS, OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS,
                 OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA,
                 OP_INC_ZP, OP_INC_ZPX, OP_INC_ABS, OP_INC_ABX,
                 OP_DEC_ZP, OP_DEC_ZPX, OP_DEC_ABS, OP_DEC_ABX,
                 OP_INX, OP_INY, OP_DEX, OP_DEY,
                 OP_SEC, OP_SED, OP_SEI, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
                 OP_JMP_ABS, OP_JMP_IND,
                 OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVS,
                 OP_BIT_ZP, OP_BIT_ABS, OP_BRK};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Loads that give zero and negative, then an add that
    // wraps to zero with carry out and one that overflows into the sign.
    send_instr(instr({GRP_LDA, 3'b010, ALU_COLUMN}, 8'h00, 16'h0000, 16'h0000));
    send_instr(instr({GRP_LDA, 3'b010, ALU_COLUMN}, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_instr(instr({GRP_ADC, 3'b010, ALU_COLUMN}, 8'h01, 16'h1234, 16'h0200));
    send_instr(instr(OP_CLC, 8'h00, 16'h0000, 16'h0201));
    send_instr(instr({GRP_LDA, 3'b010, ALU_COLUMN}, 8'h7F, 16'h0000, 16'h0202));
    send_instr(instr({GRP_ADC, 3'b010, ALU_COLUMN}, 8'h01, 16'h0000, 16'h0204));
    // Subtract with borrow and compare, after carry is set by hand.
    send_instr(instr(OP_SEC, 8'h00, 16'h0000, 16'h0206));
    send_instr(instr({GRP_SBC, 3'b010, ALU_COLUMN}, 8'h01, 16'h0000, 16'h0207));
    send_instr(instr({GRP_CMP, 3'b010, ALU_COLUMN}, 8'h7F, 16'h0000, 16'h0209));
    // Shifts and rotates on the accumulator and on memory, carry in and out.
    send_instr(instr({1'b0, SH_ASL, SHM_ACC}, 8'h00, 16'h0000, 16'h020B));
    send_instr(instr({1'b0, SH_ROR, SHM_ACC}, 8'h00, 16'h0000, 16'h020C));
    send_instr(instr({1'b0, SH_ROL, SHM_ZP}, 8'h80, 16'h00FF, 16'h020D));
    send_instr(instr({1'b0, SH_LSR, SHM_ABS}, 8'h01, 16'hFFFF, 16'h020F));
    // Memory increment and decrement across the wrap, index decrement from zero.
    send_instr(instr(OP_INC_ABX, 8'hFF, 16'hFFFF, 16'h0212));
    send_instr(instr(OP_DEC_ZP, 8'h00, 16'h0000, 16'h0215));
    send_instr(instr(OP_DEX, 8'h00, 16'h0000, 16'h0217));
    send_instr(instr(OP_TXS, 8'h00, 16'h0000, 16'h0218));
    send_instr(instr(OP_BIT_ABS, 8'hC0, 16'h4000, 16'h0219));
    // Taken branches that wrap the program counter both ways, then a jump.
    // The bit test above leaves overflow and negative set.
    send_instr(instr(OP_BVS, 8'h7F, 16'h0000, 16'hFFF0));
    send_instr(instr(OP_BMI, 8'h80, 16'h0000, 16'h0010));
    send_instr(instr(OP_JMP_IND, 8'h00, 16'hFFFF, 16'h0000));
    // Decimal mode must not change the add, and the no-op store immediate.
    send_instr(instr(OP_SED, 8'h00, 16'h0000, 16'h0300));
    send_instr(instr({GRP_ADC, 3'b010, ALU_COLUMN}, 8'h09, 16'h0000, 16'h0301));
    send_instr(instr(OP_STA_IMM, 8'hFF, 16'hFFFF, 16'h0303));
    // Halt, a request right after it, and an opcode outside the decoded set.
    send_instr(instr(OP_BRK, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_instr(instr({GRP_STA, 3'b011, ALU_COLUMN}, 8'h00, 16'hFFFF, 16'h0001));
    send_instr(instr(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));

    // Let the core run dry once before the random part.
    drain_results();

    // Random part. Every hundred requests both sides may switch to running
    // without any idle cycles, and halfway the sender waits for a full drain.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQUESTS / 2) drain_results();
      send_instr(draw_instr());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_cpu_8bit_instruction_execute_core: clean");
    end else begin
      $display("tb_cpu_8bit_instruction_execute_core: errors");
    end
    $finish;
  end

endmodule

@@ cpu_8bit_instruction_execute_core.f @@
sv/cie_pkg.sv
sv/cie_if.sv
sv/cie_exec.sv
sv/cpu_8bit_instruction_execute_core.sv
sv/cie_checker.sv
tb/sv/cie_retire_checker.sv
tb/sv/tb_cpu_8bit_instruction_execute_core.sv
